@@ hdl/gpdm_pkg.sv @@
// ----------------------------------------------------------------------------
// gpdm_pkg
// Shared sizes, opcodes and command type for the grid path digit matcher.
// ----------------------------------------------------------------------------
package gpdm_pkg;

   localparam int ROWS    = 8;
   localparam int COLS    = 14;
   localparam int CELLS   = ROWS * COLS;
   localparam int OP_W    = 2;
   localparam int IDX_W   = 7;
   localparam int DIGIT_W = 4;
   localparam int NBR_N   = 8;

   typedef logic [OP_W-1:0]    opcode_type;
   typedef logic [IDX_W-1:0]   cell_index_type;
   typedef logic [DIGIT_W-1:0] digit_type;

   localparam opcode_type OP_LOAD  = 2'd0;
   localparam opcode_type OP_FIRST = 2'd1;
   localparam opcode_type OP_NEXT  = 2'd2;

   // command broadcast from the control to every grid cell
   typedef struct packed {
      logic           load;
      logic           first;
      logic           next;
      cell_index_type cell_index;
      digit_type      digit;
   } gpdm_cmd_type;

endpackage

@@ hdl/gpdm_req_if.sv @@
// ----------------------------------------------------------------------------
// gpdm_req_if
// Request channel: opcode, cell index and digit with valid/ready.
// ----------------------------------------------------------------------------
interface gpdm_req_if;
   import gpdm_pkg::*;

   logic           valid;
   logic           ready;
   opcode_type     opcode;
   cell_index_type cell_index;
   digit_type      digit;

   modport source (output valid, output opcode, output cell_index, output digit,
                   input ready);
   modport sink   (input valid, input opcode, input cell_index, input digit,
                   output ready);
endinterface

@@ hdl/gpdm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gpdm_rsp_if
// Response channel: match_alive flag with valid/ready.
// ----------------------------------------------------------------------------
interface gpdm_rsp_if;
   logic valid;
   logic ready;
   logic match_alive;

   modport source (output valid, output match_alive, input ready);
   modport sink   (input valid, input match_alive, output ready);
endinterface

@@ hdl/gpdm_cell.sv @@
// ----------------------------------------------------------------------------
// gpdm_cell
// One grid cell: stored digit and path end mark, fed by its eight neighbors.
// ----------------------------------------------------------------------------
module gpdm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  gpdm_pkg::gpdm_cmd_type cmd,
   input  logic                   write_en,
   input  logic [gpdm_pkg::NBR_N-1:0] nbr_marks,
   output logic                   mark
);
   import gpdm_pkg::*;

   digit_type digit_ff;
   logic      mark_ff;
   logic      mark_in;
   logic      hit;

   assign hit = (digit_ff == cmd.digit);

   always_comb begin
      priority if (cmd.first) begin
         mark_in = hit;
      end else if (cmd.next) begin
         mark_in = hit && (|nbr_marks);
      end else begin
         mark_in = mark_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         digit_ff <= cmd.digit;
      end
   end

   assign mark = mark_ff;

endmodule

@@ hdl/gpdm_grid.sv @@
// ----------------------------------------------------------------------------
// gpdm_grid
// Rows-by-columns array of cells wired to king-move neighbors, with a
// registered per-row OR of the marks.
// ----------------------------------------------------------------------------
module gpdm_grid (
   input  logic                   clock,
   input  logic                   reset,
   input  gpdm_pkg::gpdm_cmd_type cmd,
   output logic                   grid_any
);
   import gpdm_pkg::*;

   logic [CELLS-1:0] marks;
   logic [ROWS-1:0]  row_any_ff;

   for (genvar r = 0; r < ROWS; r++) begin : g_row
      for (genvar c = 0; c < COLS; c++) begin : g_col
         localparam int ID = r * COLS + c;
         logic [NBR_N-1:0] nbr;
         logic             write_en;

         // k walks the 3x3 window, the center is skipped
         for (genvar k = 0; k < 9; k++) begin : g_nbr
            localparam int NR   = r + k / 3 - 1;
            localparam int NC   = c + k % 3 - 1;
            localparam int SLOT = (k < 4) ? k : k - 1;
            if (k != 4) begin : g_tap
               if (NR >= 0 && NR < ROWS && NC >= 0 && NC < COLS) begin : g_in
                  assign nbr[SLOT] = marks[NR * COLS + NC];
               end else begin : g_edge
                  assign nbr[SLOT] = 1'b0;
               end
            end
         end

         assign write_en = cmd.load && (cmd.cell_index == IDX_W'(ID));

         gpdm_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .write_en  (write_en),
            .nbr_marks (nbr),
            .mark      (marks[ID])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_any_ff <= '0;
      end else begin
         for (int r = 0; r < ROWS; r++) begin
            row_any_ff[r] <= |marks[r*COLS +: COLS];
         end
      end
   end

   assign grid_any = |row_any_ff;

endmodule

@@ hdl/grid_path_digit_matcher_core.sv @@
// ----------------------------------------------------------------------------
// grid_path_digit_matcher_core
// Digit grid with king-move path tracking; reports whether the digit
// sequence so far can still be read along a grid path.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   opcode, cell_index, digit
//   rsp_chan  out  valid/ready   match_alive
//
// A load transaction gives no response.
// A first/next digit transaction updates the cell marks at acceptance; the
// row OR register follows, then the full OR is captured in the report state.
// The response sits in an output register; a new request is taken while it
// waits, but a second response holds in the report state until it drains.
// Synchronous reset clears all marks, the state and the output valid.
// ----------------------------------------------------------------------------
module grid_path_digit_matcher_core (
   input logic      clock,
   input logic      reset,
   gpdm_req_if.sink   req_chan,
   gpdm_rsp_if.source rsp_chan
);
   import gpdm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_GATHER = 3'b010,
      ST_REPORT = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         match_ff, match_in;
   logic         req_fire;
   logic         is_digit;
   logic         grid_any;
   logic         out_free;
   gpdm_cmd_type cmd;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_digit       = (req_chan.opcode == OP_FIRST) || (req_chan.opcode == OP_NEXT);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      cmd.load       = req_fire && (req_chan.opcode == OP_LOAD);
      cmd.first      = req_fire && (req_chan.opcode == OP_FIRST);
      cmd.next       = req_fire && (req_chan.opcode == OP_NEXT);
      cmd.cell_index = req_chan.cell_index;
      cmd.digit      = req_chan.digit;
   end

   gpdm_grid u_grid (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .grid_any (grid_any)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      match_in     = match_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_digit) begin
               state_in = ST_GATHER;
            end
         end
         ST_GATHER: begin
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               match_in     = grid_any;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_alive = match_ff;

   a_digit_gathers: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_digit |=> state_ff == ST_GATHER)
      else $error("digit transaction did not start gathering");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.opcode == OP_LOAD) |=> state_ff == ST_IDLE)
      else $error("load transaction left idle");

   a_rsp_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_REPORT)
      else $error("response raised outside report");

   a_report_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPORT && rsp_valid_ff && !rsp_chan.ready |=> state_ff == ST_REPORT)
      else $error("report overwrote a pending response");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_path_digit_matcher_core. The grid is filled
// first, then a short directed list runs through the corner cases. It is
// followed by random king-move walks through the grid, with some corrupted
// digits, reloads and junk transactions mixed in. A local predictor follows
// every accepted request and queues the expected match_alive flags. The
// monitor checks the responses in order against that queue. Both channels
// idle in random bursts, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
   import gpdm_pkg::*;

   localparam opcode_type OP_UNUSED   = 2'd3;
   localparam int         RAND_ITEMS  = 1450;
   localparam int         CALM_ITEMS  = 150;
   localparam int         HOLD_AFTER  = 200;
   localparam int         HOLD_CYCLES = 80;
   localparam int         QUIET_LIMIT = 1000;
   localparam int         TAIL_CYCLES = 12;

   typedef struct packed {
      opcode_type     opcode;
      cell_index_type cell_index;
      digit_type      digit;
   } match_request_type;

   logic clock;
   logic reset;

   gpdm_req_if req_chan ();
   gpdm_rsp_if rsp_chan ();

   grid_path_digit_matcher_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // stimulus plan and its own copy of the grid for building walks
   match_request_type pending_requests [$];
   digit_type         plan_grid [CELLS];
   int                plan_lo;
   int                plan_span;
   int                useful_items;

   // predictor state
   digit_type         model_grid [CELLS];
   bit                model_mark [CELLS];
   bit                alive_expected [$];

   match_request_type on_bus;
   int                gap_left;
   logic              calm_phase;
   int                stall_left;
   int                hold_left;
   bit                hold_done;
   int                rsp_seen;
   int                errors;
   int                quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic push_item(input opcode_type op, input int idx, input int dig);
      match_request_type rq;
      rq.opcode     = op;
      rq.cell_index = cell_index_type'(idx);
      rq.digit      = digit_type'(dig);
      pending_requests = {pending_requests, rq};
      if (op == OP_LOAD && idx < CELLS)
         plan_grid[idx] = digit_type'(dig);
      if (op != OP_UNUSED && !(op == OP_LOAD && idx >= CELLS))
         useful_items++;
   endtask

   function automatic int pick_digit();
      return plan_lo + $urandom_range(0, plan_span);
   endfunction

   // load writes the grid; first/next gives next marks from the grid, current marks and digit
   task automatic apply_request(input match_request_type rq);
      bit next_mark [CELLS];
      bit any_mark;
      bit reached;
      int r, c, dr, dc, nr, nc;
      any_mark = 1'b0;
      case (rq.opcode)
         OP_LOAD: begin
            if (int'(rq.cell_index) < CELLS)
               model_grid[rq.cell_index] = rq.digit;
         end
         OP_FIRST, OP_NEXT: begin
            for (r = 0; r < ROWS; r++) begin
               for (c = 0; c < COLS; c++) begin
                  reached = (rq.opcode == OP_FIRST);
                  if (!reached) begin
                     for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                           nr = r + dr;
                           nc = c + dc;
                           if ((dr != 0 || dc != 0) && nr >= 0 && nr < ROWS &&
                               nc >= 0 && nc < COLS && model_mark[nr * COLS + nc])
                              reached = 1'b1;
                        end
                     end
                  end
                  next_mark[r * COLS + c] = reached &&
                                            (model_grid[r * COLS + c] == rq.digit);
                  any_mark |= next_mark[r * COLS + c];
               end
            end
            model_mark = next_mark;
            alive_expected = {alive_expected, any_mark};
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            apply_request(on_bus);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               on_bus = pending_requests.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.opcode     <= on_bus.opcode;
               req_chan.cell_index <= on_bus.cell_index;
               req_chan.digit      <= on_bus.digit;
               if (pending_requests.size() >= CALM_ITEMS && $urandom_range(0, 5) == 0)
                  gap_left = $urandom_range(1, 8);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         calm_phase <= (pending_requests.size() < CALM_ITEMS);
      end
   end

   // monitor and response side back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            if (alive_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual match_alive=%0b",
                        $time, rsp_chan.match_alive);
            end else if (rsp_chan.match_alive !== alive_expected[0]) begin
               errors++;
               $display("%0t: match_alive mismatch, expected %0b, actual %0b",
                        $time, alive_expected[0], rsp_chan.match_alive);
               void'(alive_expected.pop_front());
            end else begin
               void'(alive_expected.pop_front());
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
            // long hold so the core backs up and stalls its request side
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      int  i, k, len, junk_kind, r, c, nr, nc, pick, target;
      bit  timed_out;

      req_chan.valid      = 1'b0;
      req_chan.opcode     = OP_LOAD;
      req_chan.cell_index = '0;
      req_chan.digit      = '0;
      rsp_chan.ready      = 1'b0;
      reset               = 1'b1;
      calm_phase          = 1'b0;
      gap_left            = 0;
      stall_left          = 0;
      hold_left           = 0;
      hold_done           = 1'b0;
      rsp_seen            = 0;
      errors              = 0;
      useful_items        = 0;
      timed_out           = 1'b0;

      // fill every cell before any digit is matched
      for (i = 0; i < CELLS; i++)
         push_item(OP_LOAD, i, (i == 0) ? 15 : (i == CELLS - 1) ? 10 : i % 10);

      // next digit straight after reset, with all marks still clear
      push_item(OP_NEXT, 0, 0);
      // loads past the grid and the spare opcode must change nothing
      push_item(OP_LOAD, CELLS, 12);
      push_item(OP_LOAD, 127, 12);
      push_item(OP_UNUSED, 127, 15);
      push_item(OP_UNUSED, 0, 0);
      push_item(OP_FIRST, 0, 12);
      push_item(OP_NEXT, 0, 12);
      // walk from the top left corner
      push_item(OP_FIRST, 0, 15);
      push_item(OP_NEXT, 0, 1);
      push_item(OP_NEXT, 0, 5);
      push_item(OP_NEXT, 0, 0);
      push_item(OP_NEXT, 0, 15);
      push_item(OP_NEXT, 0, 3);
      // bottom right corner, with a neighbor rewritten mid sequence
      push_item(OP_FIRST, 127, 10);
      push_item(OP_LOAD, CELLS - 2, 7);
      push_item(OP_NEXT, 0, 7);
      push_item(OP_NEXT, 127, 10);
      push_item(OP_NEXT, 0, 9);
      push_item(OP_FIRST, 0, 0);
      push_item(OP_NEXT, 0, 0);
      push_item(OP_FIRST, 0, 9);
      push_item(OP_NEXT, 0, 8);

      target    = useful_items + RAND_ITEMS;
      plan_lo   = 0;
      plan_span = 2;
      for (i = 0; i < CELLS; i++)
         push_item(OP_LOAD, i, pick_digit());

      while (useful_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // king-move walk spelled from the grid, sometimes broken
            len = (pick < 5) ? $urandom_range(12, 24) : $urandom_range(1, 10);
            r = $urandom_range(0, ROWS - 1);
            c = $urandom_range(0, COLS - 1);
            push_item(OP_FIRST, $urandom_range(0, 127),
                      ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15)
                                                   : plan_grid[r * COLS + c]);
            for (k = 1; k < len; k++) begin
               if ($urandom_range(0, 9) == 0)
                  push_item(OP_LOAD, $urandom_range(0, CELLS - 1), pick_digit());
               do begin
                  nr = r + $urandom_range(0, 2) - 1;
                  nc = c + $urandom_range(0, 2) - 1;
               end while ((nr == r && nc == c) || nr < 0 || nr >= ROWS ||
                          nc < 0 || nc >= COLS);
               r = nr;
               c = nc;
               push_item(OP_NEXT, $urandom_range(0, 127),
                         ($urandom_range(0, 24) == 0) ? $urandom_range(0, 15)
                                                      : plan_grid[r * COLS + c]);
            end
         end else if (pick < 82) begin
            // new digit range, then part of the grid reloaded
            plan_span = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 9)
                                                    : $urandom_range(0, 2);
            plan_lo   = $urandom_range(0, 15 - plan_span);
            len = $urandom_range(8, 40);
            for (k = 0; k < len; k++)
               push_item(OP_LOAD, $urandom_range(0, CELLS - 1), pick_digit());
         end else begin
            // junk: spare opcode, loads past the grid, stray digits
            junk_kind = $urandom_range(0, 3);
            case (junk_kind)
               0: push_item(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 15));
               1: push_item(OP_LOAD, $urandom_range(CELLS, 127), $urandom_range(0, 15));
               2: push_item(OP_NEXT, $urandom_range(0, 127), $urandom_range(0, 15));
               default: push_item(OP_FIRST, $urandom_range(0, 127), $urandom_range(0, 15));
            endcase
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
         if (quiet_cycles >= QUIET_LIMIT)
            timed_out = 1'b1;
      end while (!timed_out && !(pending_requests.size() == 0 && !req_chan.valid &&
                                 alive_expected.size() == 0));
      if (!timed_out)
         repeat (TAIL_CYCLES) @(negedge clock);

      if (!timed_out && errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
